[sv/tksi_pkg.sv]
// tksi_pkg: shared types, widths and helpers for the top-k score insertion block
// no dependencies; imported by tksi_cell, tksi_row and top_k_score_insert
`default_nettype none

package tksi_pkg;

  localparam int MAX_KEPT_DEF = 16;
  localparam int TAG_COUNT    = 1024;
  localparam int SCORE_W      = 32;
  localparam int TAG_W        = 10;
  localparam int RANK_W       = 4;
  localparam int CAP_W        = 5;
  localparam int CAP_RESET    = 16;

  typedef enum logic [1:0] {
    OP_OFFER        = 2'd0,
    OP_OFFER_FINISH = 2'd1,
    OP_FINISH       = 2'd2,
    OP_NONE         = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic               insert;
    logic               drain;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } row_cmd_t;

  // fold a tag into 0..TAG_COUNT-1; one compare and subtract covers the 10-bit field
  function automatic logic [TAG_W-1:0] wrap_tag(input logic [TAG_W-1:0] tag);
    logic [TAG_W:0] ext;
    ext = {1'b0, tag};
    if (ext >= (TAG_W+1)'(TAG_COUNT)) begin
      wrap_tag = TAG_W'(ext - (TAG_W+1)'(TAG_COUNT));
    end else begin
      wrap_tag = tag;
    end
  endfunction

endpackage

`default_nettype wire

[sv/tksi_cell.sv]
// tksi_cell: one slot of the ranked list; compares, shifts down on insert, up on drain
// depends on tksi_pkg
`default_nettype none

module tksi_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic               clk_i,
  input  wire tksi_pkg::row_cmd_t cmd_i,
  input  wire logic [CNT_W-1:0]   count_i,
  input  wire logic [CNT_W-1:0]   cap_i,
  input  wire logic               gt_prev_i,
  input  wire tksi_pkg::entry_t   prev_i,
  input  wire tksi_pkg::entry_t   next_i,
  output logic                    gt_o,
  output tksi_pkg::entry_t        entry_o
);
  import tksi_pkg::*;

  entry_t entry_q, entry_d;
  logic   active;
  logic   occupied;

  assign active   = CNT_W'(IDX) < cap_i;
  assign occupied = CNT_W'(IDX) < count_i;
  // free slot inside capacity, or a kept score strictly below the candidate
  assign gt_o     = active && (!occupied || (cmd_i.score > entry_q.score));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert && gt_o) begin
      if (gt_prev_i) begin
        entry_d = prev_i;
      end else begin
        entry_d.score = cmd_i.score;
        entry_d.tag   = cmd_i.tag;
      end
    end else if (cmd_i.drain) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[sv/tksi_row.sv]
// tksi_row: chain of MAX_KEPT cells holding the list in descending score order
// depends on tksi_pkg and tksi_cell
`default_nettype none

module tksi_row #(
  parameter int MAX_KEPT = tksi_pkg::MAX_KEPT_DEF,
  parameter int CNT_W    = 5
) (
  input  wire logic               clk_i,
  input  wire tksi_pkg::row_cmd_t cmd_i,
  input  wire logic [CNT_W-1:0]   count_i,
  input  wire logic [CNT_W-1:0]   cap_i,
  output tksi_pkg::entry_t        head_o
);
  import tksi_pkg::*;

  entry_t entry [MAX_KEPT];
  logic   gt    [MAX_KEPT];

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    logic   gt_prev;
    entry_t prev;
    entry_t next;

    if (i == 0) begin : g_first
      assign gt_prev = 1'b0;
      assign prev    = '0;
    end else begin : g_mid
      assign gt_prev = gt[i-1];
      assign prev    = entry[i-1];
    end

    if (i == MAX_KEPT - 1) begin : g_last
      assign next = '0;
    end else begin : g_inner
      assign next = entry[i+1];
    end

    tksi_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd_i),
      .count_i   (count_i),
      .cap_i     (cap_i),
      .gt_prev_i (gt_prev),
      .prev_i    (prev),
      .next_i    (next),
      .gt_o      (gt[i]),
      .entry_o   (entry[i])
    );
  end

  assign head_o = entry[0];

endmodule

`default_nettype wire

[sv/top_k_score_insert.sv]
// top_k_score_insert: keeps the best-scoring candidates in rank order and reads them out
// depends on tksi_pkg and tksi_row (which holds the tksi_cell chain)
//
// Usage:
//   A command is transferred at a rising edge with start_i high and busy_o low.
//   operation_i selects offer (0), offer then finish (1), finish only (2); 3 is
//   ignored. An offer is compared against all kept entries at once by the cell
//   row and inserted at that same edge, so offers go at one per cycle while
//   busy_o is low, with no result. A finish raises busy_o and then shifts the
//   list out of cell 0, one result per cycle, each result registered from the
//   head cell; busy_o falls as the final result, which carries last_entry_o,
//   appears. A finish on an empty list gives one result with list_empty_o set,
//   registered at the finish transfer, without going busy. After the finish
//   the list is empty.
//   Each result is valid for exactly one cycle on out_valid_o; the receiver
//   cannot stall. cfg_we_i/cfg_wdata_i set the capacity (clamped to
//   1..MAX_KEPT), while idle only; lowering it drops the tail at once.
//   Reset empties the list and sets the capacity to 16 (or MAX_KEPT if smaller).
`default_nettype none

module top_k_score_insert #(
  parameter int MAX_KEPT = tksi_pkg::MAX_KEPT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [1:0]                   operation_i,
  input  wire logic [tksi_pkg::SCORE_W-1:0] score_i,
  input  wire logic [tksi_pkg::TAG_W-1:0]   doc_tag_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [tksi_pkg::CAP_W-1:0]   cfg_wdata_i,
  output logic                              out_valid_o,
  output logic [tksi_pkg::SCORE_W-1:0]      out_score_o,
  output logic [tksi_pkg::TAG_W-1:0]        out_tag_o,
  output logic [tksi_pkg::RANK_W-1:0]       rank_o,
  output logic                              list_empty_o,
  output logic                              last_entry_o
);
  import tksi_pkg::*;

  localparam int CNT_W   = $clog2(MAX_KEPT + 1);
  localparam int IDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CAP_RST = (MAX_KEPT < CAP_RESET) ? MAX_KEPT : CAP_RESET;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   cap_q, cap_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic [SCORE_W-1:0] out_score_q, out_score_d;
  logic [TAG_W-1:0]   out_tag_q, out_tag_d;
  logic [RANK_W-1:0]  rank_q, rank_d;
  logic               empty_q, empty_d;
  logic               last_q, last_d;

  op_e              op;
  logic             accept;
  logic             do_offer;
  logic             do_finish;
  logic [CNT_W-1:0] cnt_after;
  logic [CNT_W-1:0] cap_new;
  logic             drain_last;
  row_cmd_t         cmd;
  entry_t           head;

  assign op        = op_e'(operation_i);
  assign busy_o    = (state_q == ST_DRAIN);
  assign accept    = start_i && !busy_o;
  assign do_offer  = accept && (op inside {OP_OFFER, OP_OFFER_FINISH});
  assign do_finish = accept && (op inside {OP_OFFER_FINISH, OP_FINISH});
  assign cnt_after = (do_offer && (count_q < cap_q)) ? count_q + CNT_W'(1) : count_q;
  assign drain_last = (CNT_W'(idx_q) + CNT_W'(1)) == len_q;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_new = CNT_W'(1);
    end else if (int'(cfg_wdata_i) > MAX_KEPT) begin
      cap_new = CNT_W'(MAX_KEPT);
    end else begin
      cap_new = CNT_W'(cfg_wdata_i);
    end
  end

  assign cmd.insert = do_offer;
  assign cmd.drain  = (state_q == ST_DRAIN);
  assign cmd.score  = score_i;
  assign cmd.tag    = wrap_tag(doc_tag_i);

  tksi_row #(
    .MAX_KEPT (MAX_KEPT),
    .CNT_W    (CNT_W)
  ) u_row (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .count_i (count_q),
    .cap_i   (cap_q),
    .head_o  (head)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cap_d       = cap_q;
    len_d       = len_q;
    idx_d       = idx_q;
    out_valid_d = 1'b0;
    out_score_d = out_score_q;
    out_tag_d   = out_tag_q;
    rank_d      = rank_q;
    empty_d     = empty_q;
    last_d      = last_q;
    case (state_q)
      ST_IDLE: begin
        count_d = cnt_after;
        if (do_finish) begin
          if (cnt_after == '0) begin
            out_valid_d = 1'b1;
            out_score_d = '0;
            out_tag_d   = '0;
            rank_d      = '0;
            empty_d     = 1'b1;
            last_d      = 1'b1;
          end else begin
            state_d = ST_DRAIN;
            len_d   = cnt_after;
            idx_d   = '0;
            count_d = '0;
          end
        end
        if (cfg_we_i) begin
          cap_d = cap_new;
          if (count_d > cap_new) begin
            count_d = cap_new;
          end
        end
      end
      ST_DRAIN: begin
        // head cell is read while the row shifts up by one
        out_valid_d = 1'b1;
        out_score_d = head.score;
        out_tag_d   = head.tag;
        rank_d      = RANK_W'(idx_q);
        empty_d     = 1'b0;
        last_d      = drain_last;
        idx_d       = idx_q + IDX_W'(1);
        if (drain_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cap_q       <= CNT_W'(CAP_RST);
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_score_q <= out_score_d;
    out_tag_q   <= out_tag_d;
    rank_q      <= rank_d;
    empty_q     <= empty_d;
    last_q      <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_score_o  = out_score_q;
  assign out_tag_o    = out_tag_q;
  assign rank_o       = rank_q;
  assign list_empty_o = empty_q;
  assign last_entry_o = last_q;

`ifndef SYNTHESIS
  a_count_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("kept count above capacity");

  a_drain_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (count_q == '0) && (CNT_W'(idx_q) < len_q))
    else $error("drain index or count out of step");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && list_empty_o) |-> last_entry_o && (out_score_o == '0))
    else $error("empty result malformed");

  a_drain_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> out_valid_o && last_entry_o)
    else $error("drain ended without final result");
`endif

endmodule

`default_nettype wire
